FILE: hw/rtl/smp_pkg.sv
package smp_pkg;

   // queue depths
   localparam int MID_DEPTH_DEF = 4;
   localparam int OUT_DEPTH_DEF = 32;

   // register indexes of the configuration port
   localparam logic [2:0] CSR_STEP_LENGTH = 3'd0;
   localparam logic [2:0] CSR_VISCOSITY   = 3'd1;
   localparam logic [2:0] CSR_FORCE_X     = 3'd2;
   localparam logic [2:0] CSR_FORCE_Y     = 3'd3;
   localparam logic [2:0] CSR_INV_X       = 3'd4;
   localparam logic [2:0] CSR_INV_Y       = 3'd5;
   localparam logic [2:0] CSR_UPWIND      = 3'd6;

   localparam logic [30:0] INV_SPACING_RESET = 31'd65536;

   // intermediates live in a saturated 48-bit range
   localparam logic signed [47:0] LIM48 = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [48:0] LIM49 = 49'sh0_7FFF_FFFF_FFFF;

   typedef logic signed [47:0] wide_type;
   typedef logic signed [34:0] opnd_type;

   typedef struct packed {
      logic [30:0]        step_length;
      logic [30:0]        kinematic_viscosity;
      logic signed [31:0] body_force_x;
      logic signed [31:0] body_force_y;
      logic [30:0]        inv_spacing_x;
      logic [30:0]        inv_spacing_y;
      logic               upwind_mode;
   } cfg_type;

   // one classified face, handed from front to back
   typedef struct packed {
      logic               upwind;
      logic               blocked;
      logic signed [31:0] here;
      logic signed [31:0] force_val;
      opnd_type           c4;
      opnd_type           lap_along;
      opnd_type           lap_across;
      logic [30:0]        inv_along;
      logic [30:0]        inv_across;
      opnd_type [3:0]     mul_a;
      opnd_type [3:0]     mul_b;
      logic               wide_shift;
   } op_type;

   typedef struct packed {
      logic     clip;
      wide_type val;
   } sat_type;

   function automatic sat_type sat48(input logic signed [48:0] v);
      sat_type r;
      r.clip = 1'b0;
      if (v > LIM49) begin
         r.clip = 1'b1;
         r.val  = LIM48;
      end else if (v < -LIM49) begin
         r.clip = 1'b1;
         r.val  = -LIM48;
      end else begin
         r.val = v[47:0];
      end
      return r;
   endfunction

   function automatic wide_type wext(input opnd_type x);
      return {{13{x[34]}}, x};
   endfunction

   function automatic logic signed [48:0] sext49(input wide_type x);
      return {x[47], x};
   endfunction

endpackage

FILE: hw/rtl/smp_fifo.sv
module smp_fifo
   import smp_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hw/rtl/smp_front.sv
module smp_front
   import smp_pkg::*;
(
   input  cfg_type            cfg,
   input  logic               func,
   input  logic signed [31:0] own_here,
   input  logic signed [31:0] own_prev_along,
   input  logic signed [31:0] own_next_along,
   input  logic signed [31:0] own_prev_across,
   input  logic signed [31:0] own_next_across,
   input  logic signed [31:0] cross_back_first,
   input  logic signed [31:0] cross_back_second,
   input  logic signed [31:0] cross_front_first,
   input  logic signed [31:0] cross_front_second,
   input  logic               blocked,
   output op_type             op
);

   opnd_type h, pa, na, pc, nc, cb1, cb2, cf1, cf2;
   opnd_type c4, dir_a, dir_c, ia, ic;

   assign h   = {{3{own_here[31]}}, own_here};
   assign pa  = {{3{own_prev_along[31]}}, own_prev_along};
   assign na  = {{3{own_next_along[31]}}, own_next_along};
   assign pc  = {{3{own_prev_across[31]}}, own_prev_across};
   assign nc  = {{3{own_next_across[31]}}, own_next_across};
   assign cb1 = {{3{cross_back_first[31]}}, cross_back_first};
   assign cb2 = {{3{cross_back_second[31]}}, cross_back_second};
   assign cf1 = {{3{cross_front_first[31]}}, cross_front_first};
   assign cf2 = {{3{cross_front_second[31]}}, cross_front_second};

   // sum of the four cross values, kept unscaled
   assign c4 = cb1 + cb2 + cf1 + cf2;
   // upwind differences, zero velocity takes the forward side
   assign dir_a = (h > 0) ? h - pa : na - h;
   assign dir_c = (c4 > 0) ? h - pc : nc - h;

   always_comb begin
      op.upwind     = cfg.upwind_mode;
      op.blocked    = blocked;
      op.here       = own_here;
      op.force_val  = func ? cfg.body_force_y : cfg.body_force_x;
      op.inv_along  = func ? cfg.inv_spacing_y : cfg.inv_spacing_x;
      op.inv_across = func ? cfg.inv_spacing_x : cfg.inv_spacing_y;
      op.c4         = c4;
      op.lap_along  = pa - {h[33:0], 1'b0} + na;
      op.lap_across = pc - {h[33:0], 1'b0} + nc;
      if (cfg.upwind_mode) begin
         op.mul_a[0]   = dir_a;
         op.mul_b[0]   = ia;
         op.mul_a[1]   = dir_c;
         op.mul_b[1]   = ic;
         op.mul_a[2]   = '0;
         op.mul_b[2]   = '0;
         op.mul_a[3]   = '0;
         op.mul_b[3]   = '0;
         op.wide_shift = 1'b0;
      end else begin
         // flux products of the central form
         op.mul_a[0]   = h + na;
         op.mul_b[0]   = h + na;
         op.mul_a[1]   = pa + h;
         op.mul_b[1]   = pa + h;
         op.mul_a[2]   = h + nc;
         op.mul_b[2]   = cf1 + cf2;
         op.mul_a[3]   = pc + h;
         op.mul_b[3]   = cb1 + cb2;
         op.wide_shift = 1'b1;
      end
   end

   assign ia = {4'b0, (func ? cfg.inv_spacing_y : cfg.inv_spacing_x)};
   assign ic = {4'b0, (func ? cfg.inv_spacing_x : cfg.inv_spacing_y)};

endmodule

FILE: hw/rtl/smp_mulsh.sv
module smp_mulsh
   import smp_pkg::*;
(
   input  logic     clock,
   input  wide_type mul_a,
   input  wide_type mul_b,
   input  logic     wide_shift,
   output wide_type product,
   output logic     clip
);

   logic [47:0] mag_a, mag_b;
   logic [47:0] ll_ff;
   logic [46:0] lh_ff, hl_ff;
   logic [45:0] hh_ff;
   logic        neg1_ff, ws1_ff;
   logic [94:0] sum_ff;
   logic        neg2_ff, ws2_ff;
   logic [94:0] full_sum;
   logic [78:0] quot;
   logic [46:0] mag_q;

   assign mag_a = mul_a[47] ? 48'(-mul_a) : 48'(mul_a);
   assign mag_b = mul_b[47] ? 48'(-mul_b) : 48'(mul_b);

   // split 47-bit magnitudes into a 24-bit low half and a 23-bit high half
   always_ff @(posedge clock) begin
      ll_ff   <= mag_a[23:0] * mag_b[23:0];
      lh_ff   <= mag_a[23:0] * mag_b[46:24];
      hl_ff   <= mag_a[46:24] * mag_b[23:0];
      hh_ff   <= mag_a[46:24] * mag_b[46:24];
      neg1_ff <= mul_a[47] ^ mul_b[47];
      ws1_ff  <= wide_shift;
   end

   assign full_sum = {1'b0, hh_ff, 48'b0}
                   + ({47'b0, 1'b0, lh_ff} << 24)
                   + ({47'b0, 1'b0, hl_ff} << 24)
                   + {47'b0, ll_ff};

   // round half away from zero on the magnitude
   always_ff @(posedge clock) begin
      sum_ff  <= full_sum + (ws1_ff ? 95'd131072 : 95'd32768);
      neg2_ff <= neg1_ff;
      ws2_ff  <= ws1_ff;
   end

   assign quot  = ws2_ff ? {2'b0, sum_ff[94:18]} : sum_ff[94:16];
   assign mag_q = (quot[78:47] != '0) ? LIM48[46:0] : quot[46:0];

   always_ff @(posedge clock) begin
      clip    <= (quot[78:47] != '0);
      product <= neg2_ff ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
   end

endmodule

FILE: hw/rtl/smp_back.sv
module smp_back
   import smp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               issue,
   input  op_type             op,
   input  cfg_type            cfg,
   output logic               out_valid,
   output logic signed [31:0] predicted,
   output logic               saturated
);

   localparam int LAST = 16;

   typedef struct packed {
      opnd_type    c4;
      opnd_type    lap_along;
      opnd_type    lap_across;
      logic [30:0] inv_along;
      logic [30:0] inv_across;
   } early_type;

   typedef struct packed {
      logic               upwind;
      logic               blocked;
      logic signed [31:0] here;
      logic signed [31:0] force_val;
      wide_type           adv;
      logic               clip;
   } carry_type;

   logic [LAST:0] valid_ff;
   op_type        op0_ff;
   early_type     early_ff [1:3];
   carry_type     carry_ff [1:15];

   wide_type ra [4];
   logic     fa [4];
   wide_type ia2, ic2;
   logic     fia2, fic2;

   wide_type b_a_ff [2];
   wide_type b_b_ff [2];
   logic     b1_wide_ff;
   wide_type lapa_ff, lapc_ff, ia2_ff, ic2_ff;
   wide_type rb [2];
   logic     fb [2];
   wide_type la, lc;
   logic     fla, flc;

   wide_type lap_ff, visc, total_ff, inc;
   logic     fvisc, finc;

   sat_type d01, d23, adv_s, lap_s, t1, t2;
   logic signed [48:0] res;
   logic               range_clip;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[LAST-1:0], issue};
      end
   end
   assign out_valid = valid_ff[LAST];

   always_ff @(posedge clock) begin
      if (issue) begin
         op0_ff <= op;
      end
   end

   // first products: advection fluxes or differences, and squared reciprocals
   for (genvar k = 0; k < 4; k++) begin : g_mul_a
      smp_mulsh u_mul (
         .clock      (clock),
         .mul_a      (wext(op0_ff.mul_a[k])),
         .mul_b      (wext(op0_ff.mul_b[k])),
         .wide_shift (op0_ff.wide_shift),
         .product    (ra[k]),
         .clip       (fa[k])
      );
   end

   smp_mulsh u_ia2 (
      .clock      (clock),
      .mul_a      ({17'b0, op0_ff.inv_along}),
      .mul_b      ({17'b0, op0_ff.inv_along}),
      .wide_shift (1'b0),
      .product    (ia2),
      .clip       (fia2)
   );

   smp_mulsh u_ic2 (
      .clock      (clock),
      .mul_a      ({17'b0, op0_ff.inv_across}),
      .mul_b      ({17'b0, op0_ff.inv_across}),
      .wide_shift (1'b0),
      .product    (ic2),
      .clip       (fic2)
   );

   assign d01 = sat48(sext49(ra[0]) - sext49(ra[1]));
   assign d23 = sat48(sext49(ra[2]) - sext49(ra[3]));

   always_ff @(posedge clock) begin
      early_ff[1].c4         <= op0_ff.c4;
      early_ff[1].lap_along  <= op0_ff.lap_along;
      early_ff[1].lap_across <= op0_ff.lap_across;
      early_ff[1].inv_along  <= op0_ff.inv_along;
      early_ff[1].inv_across <= op0_ff.inv_across;
      early_ff[2]            <= early_ff[1];
      early_ff[3]            <= early_ff[2];
   end

   always_ff @(posedge clock) begin
      carry_ff[1].upwind    <= op0_ff.upwind;
      carry_ff[1].blocked   <= op0_ff.blocked;
      carry_ff[1].here      <= op0_ff.here;
      carry_ff[1].force_val <= op0_ff.force_val;
      carry_ff[1].adv       <= '0;
      carry_ff[1].clip      <= 1'b0;
      for (int k = 2; k <= 15; k++) begin
         if (k != 4 && k != 8 && k != 12) begin
            carry_ff[k] <= carry_ff[k-1];
         end
      end
      carry_ff[4].upwind     <= carry_ff[3].upwind;
      carry_ff[4].blocked    <= carry_ff[3].blocked;
      carry_ff[4].here       <= carry_ff[3].here;
      carry_ff[4].force_val  <= carry_ff[3].force_val;
      carry_ff[4].adv        <= carry_ff[3].adv;
      carry_ff[4].clip       <= carry_ff[3].clip | fa[0] | fa[1] | fa[2] | fa[3] | fia2 | fic2
                              | (!carry_ff[3].upwind & (d01.clip | d23.clip));
      carry_ff[8].upwind     <= carry_ff[7].upwind;
      carry_ff[8].blocked    <= carry_ff[7].blocked;
      carry_ff[8].here       <= carry_ff[7].here;
      carry_ff[8].force_val  <= carry_ff[7].force_val;
      carry_ff[8].adv        <= adv_s.val;
      carry_ff[8].clip       <= carry_ff[7].clip | fb[0] | fb[1] | fla | flc
                              | adv_s.clip | lap_s.clip;
      carry_ff[12].upwind    <= carry_ff[11].upwind;
      carry_ff[12].blocked   <= carry_ff[11].blocked;
      carry_ff[12].here      <= carry_ff[11].here;
      carry_ff[12].force_val <= carry_ff[11].force_val;
      carry_ff[12].adv       <= carry_ff[11].adv;
      carry_ff[12].clip      <= carry_ff[11].clip | fvisc | t1.clip | t2.clip;
   end

   // operands of the second products
   always_ff @(posedge clock) begin
      if (carry_ff[3].upwind) begin
         b_a_ff[0]  <= {{16{carry_ff[3].here[31]}}, carry_ff[3].here};
         b_b_ff[0]  <= ra[0];
         b_a_ff[1]  <= wext(early_ff[3].c4);
         b_b_ff[1]  <= ra[1];
         b1_wide_ff <= 1'b1;
      end else begin
         b_a_ff[0]  <= d01.val;
         b_b_ff[0]  <= {17'b0, early_ff[3].inv_along};
         b_a_ff[1]  <= d23.val;
         b_b_ff[1]  <= {17'b0, early_ff[3].inv_across};
         b1_wide_ff <= 1'b0;
      end
      lapa_ff <= wext(early_ff[3].lap_along);
      lapc_ff <= wext(early_ff[3].lap_across);
      ia2_ff  <= ia2;
      ic2_ff  <= ic2;
   end

   smp_mulsh u_mul_b0 (
      .clock      (clock),
      .mul_a      (b_a_ff[0]),
      .mul_b      (b_b_ff[0]),
      .wide_shift (1'b0),
      .product    (rb[0]),
      .clip       (fb[0])
   );

   smp_mulsh u_mul_b1 (
      .clock      (clock),
      .mul_a      (b_a_ff[1]),
      .mul_b      (b_b_ff[1]),
      .wide_shift (b1_wide_ff),
      .product    (rb[1]),
      .clip       (fb[1])
   );

   smp_mulsh u_lap_a (
      .clock      (clock),
      .mul_a      (lapa_ff),
      .mul_b      (ia2_ff),
      .wide_shift (1'b0),
      .product    (la),
      .clip       (fla)
   );

   smp_mulsh u_lap_c (
      .clock      (clock),
      .mul_a      (lapc_ff),
      .mul_b      (ic2_ff),
      .wide_shift (1'b0),
      .product    (lc),
      .clip       (flc)
   );

   assign adv_s = sat48(sext49(rb[0]) + sext49(rb[1]));
   assign lap_s = sat48(sext49(la) + sext49(lc));

   always_ff @(posedge clock) begin
      lap_ff <= lap_s.val;
   end

   smp_mulsh u_visc (
      .clock      (clock),
      .mul_a      ({17'b0, cfg.kinematic_viscosity}),
      .mul_b      (lap_ff),
      .wide_shift (1'b0),
      .product    (visc),
      .clip       (fvisc)
   );

   assign t1 = sat48(sext49(visc) - sext49(carry_ff[11].adv));
   assign t2 = sat48(sext49(t1.val)
                     + {{17{carry_ff[11].force_val[31]}}, carry_ff[11].force_val});

   always_ff @(posedge clock) begin
      total_ff <= t2.val;
   end

   smp_mulsh u_inc (
      .clock      (clock),
      .mul_a      ({17'b0, cfg.step_length}),
      .mul_b      (total_ff),
      .wide_shift (1'b0),
      .product    (inc),
      .clip       (finc)
   );

   assign res = {{17{carry_ff[15].here[31]}}, carry_ff[15].here} + sext49(inc);
   assign range_clip = (res > 49'sd2147483647) || (res < -49'sd2147483648);

   always_ff @(posedge clock) begin
      if (carry_ff[15].blocked) begin
         predicted <= '0;
         saturated <= 1'b0;
      end else begin
         if (res > 49'sd2147483647) begin
            predicted <= 32'sh7FFF_FFFF;
         end else if (res < -49'sd2147483648) begin
            predicted <= 32'sh8000_0000;
         end else begin
            predicted <= res[31:0];
         end
         saturated <= carry_ff[15].clip | finc | range_clip;
      end
   end

endmodule

FILE: hw/rtl/staggered_momentum_predictor.sv
// staggered-grid momentum predictor, one face per request
//
// request side looks like a queue: drive the face fields with req_push high;
// the request is taken at a clock edge where req_full is low. result side:
// while rsp_empty is low the oldest result sits on rsp_predicted and
// rsp_saturated, and rsp_pop high at an edge takes it.
// configuration goes through csr_valid/csr_index/csr_data; csr_ready is
// always high, write only while no request is in flight.
//
// throughput: one request per cycle while results are being taken.
// from accepted request to result visible the path is the front queue,
// seventeen stages of the back pipeline (four chained rounding multiplier
// levels plus add/saturate stages) and the result queue write.
// the back pipeline only starts a request when the result queue has a slot
// reserved for it, so a stalled receiver fills the result queue, then the
// front queue, and then req_full rises; nothing is dropped.
// reset (synchronous, active high) empties both queues and the pipeline and
// loads the register defaults: unit reciprocal spacings, everything else zero.
module staggered_momentum_predictor
   import smp_pkg::*;
#(
   parameter int MID_DEPTH = MID_DEPTH_DEF,
   parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_func,
   input  logic signed [31:0] req_own_here,
   input  logic signed [31:0] req_own_prev_along,
   input  logic signed [31:0] req_own_next_along,
   input  logic signed [31:0] req_own_prev_across,
   input  logic signed [31:0] req_own_next_across,
   input  logic signed [31:0] req_cross_back_first,
   input  logic signed [31:0] req_cross_back_second,
   input  logic signed [31:0] req_cross_front_first,
   input  logic signed [31:0] req_cross_front_second,
   input  logic               req_blocked,
   // result channel
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [31:0] rsp_predicted,
   output logic               rsp_saturated,
   // configuration
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   localparam int OCW = $clog2(OUT_DEPTH + 1);

   cfg_type  cfg_ff;
   op_type   front_op, mid_op;
   logic     mid_full, mid_empty, issue;
   logic     back_valid, out_full;
   logic signed [31:0] back_predicted;
   logic     back_saturated;
   logic [32:0] out_data;
   logic [OCW-1:0] outstanding_ff, outstanding_in;
   logic     rsp_take;

   // configuration registers, unknown indexes ignored
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_length         <= '0;
         cfg_ff.kinematic_viscosity <= '0;
         cfg_ff.body_force_x        <= '0;
         cfg_ff.body_force_y        <= '0;
         cfg_ff.inv_spacing_x       <= INV_SPACING_RESET;
         cfg_ff.inv_spacing_y       <= INV_SPACING_RESET;
         cfg_ff.upwind_mode         <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_STEP_LENGTH: cfg_ff.step_length         <= csr_data[30:0];
            CSR_VISCOSITY:   cfg_ff.kinematic_viscosity <= csr_data[30:0];
            CSR_FORCE_X:     cfg_ff.body_force_x        <= csr_data;
            CSR_FORCE_Y:     cfg_ff.body_force_y        <= csr_data;
            CSR_INV_X:       cfg_ff.inv_spacing_x       <= csr_data[30:0];
            CSR_INV_Y:       cfg_ff.inv_spacing_y       <= csr_data[30:0];
            CSR_UPWIND:      cfg_ff.upwind_mode         <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // front: classify the face and set up the first products
   smp_front u_front (
      .cfg                (cfg_ff),
      .func               (req_func),
      .own_here           (req_own_here),
      .own_prev_along     (req_own_prev_along),
      .own_next_along     (req_own_next_along),
      .own_prev_across    (req_own_prev_across),
      .own_next_across    (req_own_next_across),
      .cross_back_first   (req_cross_back_first),
      .cross_back_second  (req_cross_back_second),
      .cross_front_first  (req_cross_front_first),
      .cross_front_second (req_cross_front_second),
      .blocked            (req_blocked),
      .op                 (front_op)
   );

   // decoupling queue between front and back
   smp_fifo #(
      .WIDTH ($bits(op_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_op),
      .pop       (issue),
      .pop_data  (mid_op),
      .full      (mid_full),
      .empty     (mid_empty)
   );

   assign req_full = mid_full;

   // a request enters the back only with a result slot reserved
   assign rsp_take = rsp_pop && !rsp_empty;
   assign issue    = !mid_empty && (outstanding_ff < OCW'(OUT_DEPTH));

   always_comb begin
      outstanding_in = outstanding_ff;
      if (issue && !rsp_take) begin
         outstanding_in = outstanding_ff + 1'b1;
      end else if (rsp_take && !issue) begin
         outstanding_in = outstanding_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   // back: fixed-latency arithmetic pipeline
   smp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .op        (mid_op),
      .cfg       (cfg_ff),
      .out_valid (back_valid),
      .predicted (back_predicted),
      .saturated (back_saturated)
   );

   // result queue, doubles as output register
   smp_fifo #(
      .WIDTH (33),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (back_valid),
      .push_data ({back_saturated, back_predicted}),
      .pop       (rsp_pop),
      .pop_data  (out_data),
      .full      (out_full),
      .empty     (rsp_empty)
   );

   assign rsp_predicted = out_data[31:0];
   assign rsp_saturated = out_data[32];

   // reservation must keep the result queue from overflowing
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      !(back_valid && out_full))
      else $error("result queue written while full");

   a_outstanding_bound : assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= OCW'(OUT_DEPTH))
      else $error("reserved result slots exceed queue depth");

   a_idle_empty : assert property (@(posedge clock) disable iff (reset)
      (outstanding_ff == '0) |-> rsp_empty)
      else $error("result present with nothing reserved");

   a_issue_counts : assert property (@(posedge clock) disable iff (reset)
      (issue && !rsp_take) |=> (outstanding_ff == $past(outstanding_ff) + 1'b1))
      else $error("issue not counted");

endmodule
